[hdl/jcg_pkg.sv]
// shared types, constants and tables of the joint command gate and mimic block
package jcg_pkg;

   localparam int ACTIVE_JOINTS = 10;
   localparam int ALL_JOINTS    = 16;
   localparam int ANGLE_BITS    = 16;
   localparam int JIDX_BITS     = $clog2(ALL_JOINTS);
   localparam int CMD_BITS      = 2;
   localparam int TOL_BITS      = 15;
   localparam int TICK_BITS     = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 15;
   localparam int DIFF_BITS     = ANGLE_BITS + 1;

   localparam int MIMIC_JOBS    = 6;
   localparam int JOB_BITS      = 3;
   localparam int STEP_BITS     = 2;
   localparam int COEF_BITS     = 19;
   localparam int ACC_BITS      = 26;
   localparam int PROD_BITS     = ACC_BITS + ANGLE_BITS;

   localparam int REQ_DATA_BITS = ACTIVE_JOINTS * ANGLE_BITS;
   localparam int RSP_USED_BITS = JIDX_BITS + ANGLE_BITS + 1;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RSP_USED_BITS;

   localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

   // input command codes
   localparam logic [CMD_BITS-1:0] CMD_FEEDBACK = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_COMMAND  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_TICK     = 2'd2;

   // result kinds
   localparam logic RK_STATE   = 1'b0;
   localparam logic RK_COMMAND = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALIGN_TOL  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANGE_THR = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIMEOUT    = 2'd2;

   localparam logic [TOL_BITS-1:0]  ALIGN_TOL_RESET  = 15'd410;
   localparam logic [TOL_BITS-1:0]  CHANGE_THR_RESET = 15'd4;
   localparam logic [TICK_BITS-1:0] TIMEOUT_RESET    = 8'd50;

   typedef enum logic [1:0] {
      KIND_FEEDBACK,
      KIND_COMMAND,
      KIND_TICK
   } item_kind_type;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;

   typedef struct packed {
      item_kind_type                          kind;
      logic [ACTIVE_JOINTS-1:0][ANGLE_BITS-1:0] angles;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DISPATCH,
      BK_MSTART,
      BK_MIMIC,
      BK_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      MIM_IDLE,
      MIM_MUL,
      MIM_ACC
   } mimic_state_type;

   typedef struct packed {
      logic                         start;
      logic [JOB_BITS-1:0]          job;
      logic signed [ANGLE_BITS-1:0] x;
   } mimic_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [ANGLE_BITS-1:0] result;
   } mimic_rsp_type;

   // cache slot of each active joint
   function automatic logic [JIDX_BITS-1:0] active_slot(input logic [JIDX_BITS-1:0] i);
      logic [JIDX_BITS-1:0] s;
      case (i)
         4'd0:    s = 4'd0;
         4'd1:    s = 4'd1;
         4'd2:    s = 4'd2;
         4'd3:    s = 4'd5;
         4'd4:    s = 4'd6;
         4'd5:    s = 4'd8;
         4'd6:    s = 4'd10;
         4'd7:    s = 4'd11;
         4'd8:    s = 4'd13;
         4'd9:    s = 4'd14;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   // active joint that drives each passive joint
   function automatic logic [JIDX_BITS-1:0] mimic_src(input logic [JOB_BITS-1:0] job);
      logic [JIDX_BITS-1:0] s;
      case (job)
         3'd0, 3'd1: s = 4'd2;
         3'd2:       s = 4'd4;
         3'd3:       s = 4'd5;
         3'd4:       s = 4'd7;
         3'd5:       s = 4'd9;
         default:    s = 4'd2;
      endcase
      return s;
   endfunction

   // cache slot each passive joint lands in
   function automatic logic [JIDX_BITS-1:0] mimic_slot(input logic [JOB_BITS-1:0] job);
      logic [JIDX_BITS-1:0] s;
      case (job)
         3'd0:    s = 4'd3;
         3'd1:    s = 4'd4;
         3'd2:    s = 4'd7;
         3'd3:    s = 4'd9;
         3'd4:    s = 4'd12;
         3'd5:    s = 4'd15;
         default: s = 4'd3;
      endcase
      return s;
   endfunction

   // index of the last coefficient of each polynomial
   function automatic logic [STEP_BITS-1:0] mimic_last(input logic [JOB_BITS-1:0] job);
      logic [STEP_BITS-1:0] s;
      case (job)
         3'd0:    s = 2'd0;
         3'd1:    s = 2'd2;
         default: s = 2'd3;
      endcase
      return s;
   endfunction

   // Q16 coefficients, highest order first
   function automatic logic signed [COEF_BITS-1:0] mimic_coef(input logic [JOB_BITS-1:0] job,
                                                              input logic [STEP_BITS-1:0] step);
      logic signed [COEF_BITS-1:0] c;
      if (job == 3'd0) begin
         c = 19'sd87163;
      end else if (job == 3'd1) begin
         case (step)
            2'd0:    c = 19'sd18350;
            2'd1:    c = 19'sd55902;
            default: c = 19'sd120979;
         endcase
      end else begin
         case (step)
            2'd0:    c = -19'sd10945;
            2'd1:    c = 19'sd48955;
            2'd2:    c = -19'sd93389;
            default: c = 19'sd143655;
         endcase
      end
      return c;
   endfunction

endpackage

[hdl/jcg_front.sv]
// front end: accepts items, decodes the command and queues them for the back end
module jcg_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [jcg_pkg::REQ_DATA_BITS-1:0] req_tdata,  // angle_0 .. angle_9
   input  logic [jcg_pkg::CMD_BITS-1:0] req_tuser,       // command
   output logic                         q_valid,
   output jcg_pkg::item_type            q_item,
   input  logic                         q_pop
);
   import jcg_pkg::*;

   localparam int QDEPTH = 2;

   item_type         slot_ff [QDEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   item_kind_type    kind;
   logic             known;
   logic             push;

   always_comb begin
      kind  = KIND_FEEDBACK;
      known = 1'b1;
      case (req_tuser)
         CMD_FEEDBACK: kind = KIND_FEEDBACK;
         CMD_COMMAND:  kind = KIND_COMMAND;
         CMD_TICK:     kind = KIND_TICK;
         default:      known = 1'b0;   // unused code is swallowed
      endcase
   end

   assign req_tready = (count_ff != 2'(QDEPTH));
   assign push       = req_tvalid && req_tready && known;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{kind: kind, angles: req_tdata};
      end
   end

endmodule

[hdl/jcg_mimic.sv]
// shared multiply-accumulate unit that evaluates the passive joint polynomials
module jcg_mimic (
   input  logic                   clock,
   input  logic                   reset,
   input  jcg_pkg::mimic_req_type mim_req,
   output jcg_pkg::mimic_rsp_type mim_rsp
);
   import jcg_pkg::*;

   localparam logic signed [PROD_BITS-1:0] R12_HALF = PROD_BITS'(2048);
   localparam logic signed [PROD_BITS-1:0] R16_HALF = PROD_BITS'(32768);
   localparam logic signed [PROD_BITS-1:0] ANG_MAX  =
      PROD_BITS'((longint'(1) << (ANGLE_BITS - 1)) - 1);
   localparam logic signed [PROD_BITS-1:0] ANG_MIN  = -ANG_MAX - PROD_BITS'(1);

   mimic_state_type               state_ff, state_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [STEP_BITS-1:0]          step_ff, step_in;
   logic signed [PROD_BITS-1:0]   prod_r12;
   logic signed [PROD_BITS-1:0]   prod_r16;
   logic                          final_step;

   assign prod_r12   = (prod_ff + R12_HALF) >>> 12;
   assign prod_r16   = (prod_ff + R16_HALF) >>> 16;
   assign final_step = (step_ff == mimic_last(mim_req.job));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MIM_IDLE: if (mim_req.start) state_in = MIM_MUL;
         MIM_MUL:  state_in = MIM_ACC;
         MIM_ACC:  state_in = final_step ? MIM_IDLE : MIM_MUL;
         default:  state_in = MIM_IDLE;
      endcase
   end

   always_comb begin
      acc_in          = acc_ff;
      prod_in         = prod_ff;
      step_in         = step_ff;
      mim_rsp.done    = 1'b0;
      mim_rsp.result  = '0;
      case (state_ff)
         MIM_IDLE: begin
            acc_in  = ACC_BITS'(mimic_coef(mim_req.job, '0));
            step_in = '0;
         end
         MIM_MUL: begin
            prod_in = acc_ff * $signed(mim_req.x);
         end
         MIM_ACC: begin
            if (final_step) begin
               mim_rsp.done = 1'b1;
               if (prod_r16 > ANG_MAX) begin
                  mim_rsp.result = ANGLE_BITS'(ANG_MAX);
               end else if (prod_r16 < ANG_MIN) begin
                  mim_rsp.result = ANGLE_BITS'(ANG_MIN);
               end else begin
                  mim_rsp.result = ANGLE_BITS'(prod_r16);
               end
            end else begin
               acc_in  = ACC_BITS'(mimic_coef(mim_req.job, step_ff + 2'd1)) +
                         ACC_BITS'(prod_r12);
               step_in = step_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MIM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
   end

endmodule

[hdl/jcg_back.sv]
// back end: joint cache, gate, tick timer, result sequencing and registers
module jcg_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  jcg_pkg::item_type                    q_item,
   output logic                                 q_pop,
   input  logic                                 csr_we,
   input  logic [jcg_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [jcg_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [jcg_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // joint_index, angle, driver_online
   output logic                                 rsp_tuser,  // result_kind
   output logic                                 rsp_tlast,
   output jcg_pkg::mimic_req_type               mim_req,
   input  jcg_pkg::mimic_rsp_type               mim_rsp
);
   import jcg_pkg::*;

   back_state_type          state_ff, state_in;
   item_type                item_ff, item_in;
   angle_type               cache_ff [ALL_JOINTS];
   angle_type               cache_in [ALL_JOINTS];
   angle_type               prev_ff  [ACTIVE_JOINTS];
   angle_type               prev_in  [ACTIVE_JOINTS];
   logic                    has_fb_ff, has_fb_in;
   logic                    online_ff, online_in;
   logic                    gate_ff, gate_in;
   logic [TICK_BITS-1:0]    ticks_ff, ticks_in;
   logic [JOB_BITS-1:0]     job_ff, job_in;
   logic [JIDX_BITS-1:0]    cnt_ff, cnt_in;
   logic                    emit_cmd_ff, emit_cmd_in;
   logic [TOL_BITS-1:0]     align_tol_ff, align_tol_in;
   logic [TOL_BITS-1:0]     change_thr_ff, change_thr_in;
   logic [TICK_BITS-1:0]    timeout_ff, timeout_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [JIDX_BITS-1:0]    rsp_idx_ff, rsp_idx_in;
   angle_type               rsp_angle_ff, rsp_angle_in;
   logic                    rsp_online_ff, rsp_online_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic signed [DIFF_BITS-1:0] diff [ACTIVE_JOINTS];
   logic [DIFF_BITS-1:0]        mag  [ACTIVE_JOINTS];
   logic [ACTIVE_JOINTS-1:0]    exceed;
   logic [TOL_BITS-1:0]         limit;
   angle_type                   ref_ang [ACTIVE_JOINTS];
   logic [TICK_BITS-1:0]        ticks_next;
   logic                        out_free;
   logic                        emit_last;

   // closed gate compares with feedback, open gate with the previous command
   always_comb begin
      limit = gate_ff ? change_thr_ff : align_tol_ff;
      for (int i = 0; i < ACTIVE_JOINTS; i++) begin
         ref_ang[i] = gate_ff ? prev_ff[i] : cache_ff[active_slot(JIDX_BITS'(i))];
         diff[i]    = DIFF_BITS'($signed(item_ff.angles[i])) - DIFF_BITS'(ref_ang[i]);
         mag[i]     = diff[i][DIFF_BITS-1] ? DIFF_BITS'(-diff[i]) : DIFF_BITS'(diff[i]);
         exceed[i]  = mag[i] > DIFF_BITS'(limit);
      end
   end

   assign ticks_next = (ticks_ff == TICK_MAX) ? ticks_ff : ticks_ff + TICK_BITS'(1);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_last  = emit_cmd_ff ? (cnt_ff == JIDX_BITS'(ACTIVE_JOINTS - 1))
                                   : (cnt_ff == JIDX_BITS'(ALL_JOINTS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (q_valid) state_in = BK_DISPATCH;
         BK_DISPATCH: begin
            case (item_ff.kind)
               KIND_FEEDBACK: state_in = BK_MSTART;
               KIND_TICK:     state_in = has_fb_ff ? BK_EMIT : BK_IDLE;
               KIND_COMMAND:  state_in = (online_ff && gate_ff && (|exceed)) ? BK_EMIT
                                                                              : BK_IDLE;
               default:       state_in = BK_IDLE;
            endcase
         end
         BK_MSTART: state_in = BK_MIMIC;
         BK_MIMIC: begin
            if (mim_rsp.done) begin
               state_in = (job_ff == JOB_BITS'(MIMIC_JOBS - 1)) ? BK_IDLE : BK_MSTART;
            end
         end
         BK_EMIT: if (out_free && emit_last) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      item_in       = item_ff;
      cache_in      = cache_ff;
      prev_in       = prev_ff;
      has_fb_in     = has_fb_ff;
      online_in     = online_ff;
      gate_in       = gate_ff;
      ticks_in      = ticks_ff;
      job_in        = job_ff;
      cnt_in        = cnt_ff;
      emit_cmd_in   = emit_cmd_ff;
      align_tol_in  = align_tol_ff;
      change_thr_in = change_thr_ff;
      timeout_in    = timeout_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_angle_in  = rsp_angle_ff;
      rsp_online_in = rsp_online_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      mim_req.start = 1'b0;
      mim_req.job   = job_ff;
      mim_req.x     = $signed(item_ff.angles[mimic_src(job_ff)]);

      if (csr_we) begin
         case (csr_index)
            CSR_ALIGN_TOL:  align_tol_in  = csr_wdata[TOL_BITS-1:0];
            CSR_CHANGE_THR: change_thr_in = csr_wdata[TOL_BITS-1:0];
            CSR_TIMEOUT:    timeout_in    = csr_wdata[TICK_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
            end
         end
         BK_DISPATCH: begin
            cnt_in = '0;
            case (item_ff.kind)
               KIND_FEEDBACK: begin
                  for (int i = 0; i < ACTIVE_JOINTS; i++) begin
                     cache_in[active_slot(JIDX_BITS'(i))] = $signed(item_ff.angles[i]);
                  end
                  has_fb_in = 1'b1;
                  online_in = 1'b1;
                  ticks_in  = '0;
                  job_in    = '0;
               end
               KIND_TICK: begin
                  emit_cmd_in = 1'b0;
                  if (has_fb_ff) begin
                     ticks_in = ticks_next;
                     if (ticks_next > timeout_ff) online_in = 1'b0;
                  end
               end
               KIND_COMMAND: begin
                  emit_cmd_in = 1'b1;
                  if (online_ff) begin
                     for (int i = 0; i < ACTIVE_JOINTS; i++) begin
                        prev_in[i] = $signed(item_ff.angles[i]);
                     end
                     if (!gate_ff && !(|exceed)) gate_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         BK_MSTART: begin
            mim_req.start = 1'b1;
         end
         BK_MIMIC: begin
            if (mim_rsp.done) begin
               cache_in[mimic_slot(job_ff)] = mim_rsp.result;
               job_in = job_ff + JOB_BITS'(1);
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = emit_cmd_ff ? RK_COMMAND : RK_STATE;
               rsp_idx_in    = cnt_ff;
               rsp_angle_in  = emit_cmd_ff ? $signed(item_ff.angles[cnt_ff]) : cache_ff[cnt_ff];
               rsp_online_in = online_ff;
               rsp_last_in   = emit_last;
               cnt_in        = cnt_ff + JIDX_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         for (int i = 0; i < ACTIVE_JOINTS; i++) prev_ff[i] <= '0;
         has_fb_ff     <= 1'b0;
         online_ff     <= 1'b0;
         gate_ff       <= 1'b0;
         ticks_ff      <= '0;
         align_tol_ff  <= ALIGN_TOL_RESET;
         change_thr_ff <= CHANGE_THR_RESET;
         timeout_ff    <= TIMEOUT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_ff       <= prev_in;
         has_fb_ff     <= has_fb_in;
         online_ff     <= online_in;
         gate_ff       <= gate_in;
         ticks_ff      <= ticks_in;
         align_tol_ff  <= align_tol_in;
         change_thr_ff <= change_thr_in;
         timeout_ff    <= timeout_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      cache_ff      <= cache_in;
      job_ff        <= job_in;
      cnt_ff        <= cnt_in;
      emit_cmd_ff   <= emit_cmd_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_online_ff <= rsp_online_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {RSP_PAD_BITS'(0), rsp_online_ff, rsp_angle_ff, rsp_idx_ff};

endmodule

[hdl/joint_command_gate_and_mimic.sv]
// top level of the joint command gate and passive joint mimic block
//
// Takes feedback, trajectory commands and republish ticks for a hand with
// ten active joints, angles in Q3.12 radians. Items enter through a
// two-entry queue, so the input keeps accepting until both entries are
// full while the back end works and while a result waits in the output
// register. The back end runs one item at a time: a tick passes dispatch
// and then one emit step per result, a command passes dispatch and emits
// only when it is forwarded, and feedback waits on the single shared
// multiplier that evaluates the six passive joint polynomials one
// coefficient at a time. Ticks before the first feedback and commands while
// the driver is offline give no results; command code 3 is dropped at the
// input. The cache needs no clearing pass after reset, so items are taken
// from the first cycle. Register writes land at once and are meant for idle periods only.
module joint_command_gate_and_mimic (
   input  logic                                 clock,
   input  logic                                 reset,
   // request transactions
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [jcg_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // angle_0 .. angle_9, 16 bits each
   input  logic [jcg_pkg::CMD_BITS-1:0]         req_tuser,  // command
   // response transactions
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [jcg_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // joint_index, angle, driver_online
   output logic                                 rsp_tuser,  // result_kind
   output logic                                 rsp_tlast,
   // register writes
   input  logic                                 csr_we,
   input  logic [jcg_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [jcg_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import jcg_pkg::*;

   logic          q_valid;
   item_type      q_item;
   logic          q_pop;
   mimic_req_type mim_req;
   mimic_rsp_type mim_rsp;

   // decode and queue
   jcg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // cache, gate, timer and result sequencing
   jcg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mim_req    (mim_req),
      .mim_rsp    (mim_rsp)
   );

   // passive joint polynomials on one multiplier
   jcg_mimic u_mimic (
      .clock   (clock),
      .reset   (reset),
      .mim_req (mim_req),
      .mim_rsp (mim_rsp)
   );

endmodule

[hdl/jcg_checker.sv]
// port-level checks on the response channel, bound to the top level
module jcg_rsp_checks (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [jcg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);
   import jcg_pkg::*;

   logic [JIDX_BITS-1:0] idx;
   assign idx = rsp_tdata[JIDX_BITS-1:0];

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // runs close on the right joint
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         ((rsp_tuser == RK_COMMAND) ? (idx == JIDX_BITS'(ACTIVE_JOINTS - 1))
                                    : (idx == JIDX_BITS'(ALL_JOINTS - 1))))
      else $error("run ended on wrong joint");

   // motor commands only address active joints
   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == RK_COMMAND) |-> idx < JIDX_BITS'(ACTIVE_JOINTS))
      else $error("command result beyond active joints");

   // a run streams without gaps, same kind, next joint
   a_run_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (idx == $past(idx) + JIDX_BITS'(1)) && (rsp_tuser == $past(rsp_tuser)))
      else $error("run broken or out of order");

endmodule

bind joint_command_gate_and_mimic jcg_rsp_checks u_jcg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[dv/jcg_checker.sv]
`timescale 1ns / 100ps
// checker for the joint command gate and mimic block: predicts results and compares them
module jcg_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [jcg_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic [jcg_pkg::CMD_BITS-1:0]       req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [jcg_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                               rsp_tuser,
   input  logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [jcg_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [jcg_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 mismatch_count,
   output int                                 results_due,
   output int                                 results_checked
);
   import jcg_pkg::*;

   typedef struct {
      logic                  kind;
      logic [JIDX_BITS-1:0]  joint;
      logic [ANGLE_BITS-1:0] angle;
      logic                  online;
      logic                  last;
   } joint_result_type;

   joint_result_type joint_results_due[$];

   longint joint_cache [ALL_JOINTS];
   longint prev_command [ACTIVE_JOINTS];
   bit     fb_seen;
   bit     drv_online;
   bit     gate_open;
   int     ticks_idle;
   int     align_tol;
   int     change_thr;
   int     timeout_lim;

   // round half up, then floor divide
   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_angle(longint v);
      longint hi;
      hi = (longint'(1) << (ANGLE_BITS - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint abs_diff(longint x, longint y);
      return (x > y) ? x - y : y - x;
   endfunction

   function automatic int cache_slot(int j);
      case (j)
         3: return 5;
         4: return 6;
         5: return 8;
         6: return 10;
         7: return 11;
         8: return 13;
         9: return 14;
         default: return j;
      endcase
   endfunction

   // q16 coefficients, highest order first
   function automatic longint dip_coef(bit finger, int k);
      if (finger) begin
         case (k)
            0: return -10945;
            1: return 48955;
            2: return -93389;
            default: return 143655;
         endcase
      end
      case (k)
         0: return 18350;
         1: return 55902;
         default: return 120979;
      endcase
   endfunction

   function automatic longint dip_angle(bit finger, longint x);
      longint acc;
      int     terms;
      terms = finger ? 4 : 3;
      acc = dip_coef(finger, 0);
      for (int k = 1; k < terms; k++) acc = dip_coef(finger, k) + round_shift(acc * x, 12);
      return clamp_angle(round_shift(acc * x, 16));
   endfunction

   task automatic queue_result(logic kind, int joint, longint ang, logic last);
      joint_result_type r;
      r.kind   = kind;
      r.joint  = joint[JIDX_BITS-1:0];
      r.angle  = ang[ANGLE_BITS-1:0];
      r.online = drv_online;
      r.last   = last;
      joint_results_due.push_back(r);
   endtask

   task automatic gate_and_mimic(logic [CMD_BITS-1:0] code, logic [REQ_DATA_BITS-1:0] data);
      longint a [ACTIVE_JOINTS];
      bit     moved;
      bit     aligned;
      for (int j = 0; j < ACTIVE_JOINTS; j++)
         a[j] = longint'($signed(data[j*ANGLE_BITS +: ANGLE_BITS]));
      case (code)
         CMD_FEEDBACK: begin
            for (int j = 0; j < ACTIVE_JOINTS; j++) joint_cache[cache_slot(j)] = a[j];
            joint_cache[3]  = clamp_angle(round_shift(longint'(87163) * a[2], 16));
            joint_cache[4]  = dip_angle(1'b0, a[2]);
            joint_cache[7]  = dip_angle(1'b1, a[4]);
            joint_cache[9]  = dip_angle(1'b1, a[5]);
            joint_cache[12] = dip_angle(1'b1, a[7]);
            joint_cache[15] = dip_angle(1'b1, a[9]);
            fb_seen    = 1'b1;
            drv_online = 1'b1;
            ticks_idle = 0;
         end
         CMD_TICK: begin
            if (fb_seen) begin
               if (ticks_idle < int'(TICK_MAX)) ticks_idle++;
               if (drv_online && ticks_idle > timeout_lim) drv_online = 1'b0;
               for (int s = 0; s < ALL_JOINTS; s++)
                  queue_result(RK_STATE, s, joint_cache[s], s == ALL_JOINTS - 1);
            end
         end
         CMD_COMMAND: begin
            if (drv_online && !gate_open) begin
               aligned = 1'b1;
               for (int j = 0; j < ACTIVE_JOINTS; j++)
                  if (abs_diff(a[j], joint_cache[cache_slot(j)]) > align_tol) aligned = 1'b0;
               for (int j = 0; j < ACTIVE_JOINTS; j++) prev_command[j] = a[j];
               if (aligned) gate_open = 1'b1;
            end else if (drv_online) begin
               moved = 1'b0;
               for (int j = 0; j < ACTIVE_JOINTS; j++)
                  if (abs_diff(a[j], prev_command[j]) > change_thr) moved = 1'b1;
               for (int j = 0; j < ACTIVE_JOINTS; j++) prev_command[j] = a[j];
               if (moved)
                  for (int j = 0; j < ACTIVE_JOINTS; j++)
                     queue_result(RK_COMMAND, j, a[j], j == ACTIVE_JOINTS - 1);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result();
      joint_result_type      want;
      logic [JIDX_BITS-1:0]  got_joint;
      logic [ANGLE_BITS-1:0] got_angle;
      logic                  got_online;
      got_joint  = rsp_tdata[JIDX_BITS-1:0];
      got_angle  = rsp_tdata[JIDX_BITS +: ANGLE_BITS];
      got_online = rsp_tdata[JIDX_BITS + ANGLE_BITS];
      if (joint_results_due.size() == 0) begin
         if (mismatch_count < 10)
            $display("%t unexpected result: kind %0d joint %0d angle %0d", $realtime,
                     rsp_tuser, got_joint, $signed(got_angle));
         mismatch_count++;
      end else begin
         want = joint_results_due.pop_front();
         if (want.kind !== rsp_tuser || want.joint !== got_joint || want.angle !== got_angle
             || want.online !== got_online || want.last !== rsp_tlast) begin
            if (mismatch_count < 10) begin
               $write("%t mismatch (exp/got): kind %0d/%0d joint %0d/%0d angle %0d/%0d",
                      $realtime, want.kind, rsp_tuser, want.joint, got_joint,
                      $signed(want.angle), $signed(got_angle));
               $display(" online %0d/%0d last %0d/%0d", want.online, got_online,
                        want.last, rsp_tlast);
            end
            mismatch_count++;
         end else begin
            results_checked++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         joint_results_due.delete();
         for (int s = 0; s < ALL_JOINTS; s++) joint_cache[s] = 0;
         for (int j = 0; j < ACTIVE_JOINTS; j++) prev_command[j] = 0;
         fb_seen         = 1'b0;
         drv_online      = 1'b0;
         gate_open       = 1'b0;
         ticks_idle      = 0;
         align_tol       = ALIGN_TOL_RESET;
         change_thr      = CHANGE_THR_RESET;
         timeout_lim     = TIMEOUT_RESET;
         mismatch_count  = 0;
         results_checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ALIGN_TOL:  align_tol   = csr_wdata[TOL_BITS-1:0];
               CSR_CHANGE_THR: change_thr  = csr_wdata[TOL_BITS-1:0];
               CSR_TIMEOUT:    timeout_lim = csr_wdata[TICK_BITS-1:0];
               default: ;
            endcase
         end
         // results first: a result can never stem from the item taken at the same edge
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) gate_and_mimic(req_tuser, req_tdata);
      end
      results_due = joint_results_due.size();
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// testbench top for the joint command gate and mimic block: stimulus, idling and verdict
module testbench;
   import jcg_pkg::*;

   // command code the block drops
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   localparam int DRAIN_CYCLES   = 200;   // longer than three feedback passes through the mimic
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all

   typedef logic [ACTIVE_JOINTS-1:0][ANGLE_BITS-1:0] angle_set_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // angle_0 .. angle_9, 16 bits each
   logic [CMD_BITS-1:0]      req_tuser;   // command
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // joint_index, angle, driver_online
   logic                     rsp_tuser;   // result_kind
   logic                     rsp_tlast;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   int mismatch_count;
   int results_due;
   int results_checked;

   // stimulus shaping state
   int            send_idle_pct;
   int            rsp_stall_pct;
   bit            hold_asked;
   int            items_sent;
   angle_set_type fb_set;
   angle_set_type cmd_set;
   int            cur_tol;
   int            cur_thr;

   joint_command_gate_and_mimic i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   jcg_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_due     (results_due),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- helpers

   function automatic logic [ANGLE_BITS-1:0] clip16(int v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[ANGLE_BITS-1:0];
   endfunction

   function automatic int angle_of(angle_set_type s, int j);
      return int'($signed(s[j]));
   endfunction

   function automatic angle_set_type random_set();
      angle_set_type s;
      for (int j = 0; j < ACTIVE_JOINTS; j++) s[j] = ANGLE_BITS'($urandom_range(0, 65535));
      return s;
   endfunction

   function automatic angle_set_type uniform_set(logic [ANGLE_BITS-1:0] v);
      angle_set_type s;
      for (int j = 0; j < ACTIVE_JOINTS; j++) s[j] = v;
      return s;
   endfunction

   // every joint jittered by up to +-spread around base
   function automatic angle_set_type near_set(angle_set_type base, int spread);
      angle_set_type s;
      for (int j = 0; j < ACTIVE_JOINTS; j++)
         s[j] = clip16(angle_of(base, j) + int'($urandom_range(0, 2 * spread)) - spread);
      return s;
   endfunction

   function automatic angle_set_type shift_joint(angle_set_type s, int j, int delta);
      angle_set_type r;
      r = s;
      r[j] = clip16(angle_of(s, j) + delta);
      return r;
   endfunction

   // one request transaction, with random sender idling in front of it;
   // returns at the edge that takes it, valid stays up for the next call
   task automatic offer(logic [CMD_BITS-1:0] code, angle_set_type s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= random_set();
         req_tuser  <= CMD_BITS'($urandom_range(0, 3));
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tuser  <= code;
      do @(posedge clock); while (!req_tready);
      if (code != CMD_UNUSED) items_sent++;
      if (code == CMD_FEEDBACK) fb_set = s;
      if (code == CMD_COMMAND) cmd_set = s;
   endtask

   // sender stops until every expected result is back and the back end has gone quiet
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_ALIGN_TOL) cur_tol = value;
      if (idx == CSR_CHANGE_THR) cur_thr = value;
   endtask

   task automatic setup_phase(int tol, int thr, int tmo);
      settle();
      write_reg(CSR_ALIGN_TOL, tol);
      write_reg(CSR_CHANGE_THR, thr);
      write_reg(CSR_TIMEOUT, tmo);
   endtask

   // mostly well formed traffic: feedback near the last one, commands that move
   // just past or stay just inside the change threshold, and plenty of ticks
   task automatic random_item();
      int            pick;
      int            j;
      angle_set_type s;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         s = ($urandom_range(0, 3) == 0) ? random_set() : near_set(fb_set, 300);
         offer(CMD_FEEDBACK, s);
      end else if (pick < 55) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               j = $urandom_range(0, ACTIVE_JOINTS - 1);
               s = shift_joint(near_set(cmd_set, cur_thr), j,
                               (($urandom_range(0, 1) == 0) ? 1 : -1)
                               * (cur_thr + 1 + int'($urandom_range(0, 40))));
            end
            5, 6:    s = near_set(cmd_set, cur_thr);
            7:       s = random_set();
            default: s = near_set(fb_set, cur_tol);
         endcase
         offer(CMD_COMMAND, s);
      end else if (pick < 93) begin
         offer(CMD_TICK, random_set());
      end else begin
         offer(CMD_UNUSED, random_set());
      end
   endtask

   task automatic send_random(int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) random_item();
   endtask

   // ---------------------------------------------------------------- receiver

   // random back-pressure, plus one long hold-off on request
   initial begin
      int hold_left;
      bit hold_given;
      hold_left  = 0;
      hold_given = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked && !hold_given) begin
            hold_given = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      angle_set_type probe;
      angle_set_type step;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = CMD_FEEDBACK;
      csr_we        = 1'b0;
      csr_index     = CSR_ALIGN_TOL;
      csr_wdata     = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_asked    = 1'b0;
      items_sent    = 0;
      fb_set        = '0;
      cmd_set       = '0;
      cur_tol       = ALIGN_TOL_RESET;
      cur_thr       = CHANGE_THR_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // ---- directed part, register reset values
      offer(CMD_TICK, random_set());                 // tick before any feedback: silent
      offer(CMD_COMMAND, random_set());              // command while offline: ignored
      offer(CMD_UNUSED, random_set());               // unused code: dropped
      offer(CMD_FEEDBACK, uniform_set(16'h7fff));    // positive rail through the mimic
      offer(CMD_TICK, random_set());
      offer(CMD_FEEDBACK, uniform_set(16'h8000));    // negative rail
      offer(CMD_TICK, random_set());
      offer(CMD_FEEDBACK, random_set());
      offer(CMD_TICK, random_set());
      for (int j = 0; j < ACTIVE_JOINTS; j++) probe[j] = clip16(j * 3000 - 13000);
      offer(CMD_FEEDBACK, probe);
      // one joint just outside the tolerance keeps the gate shut
      offer(CMD_COMMAND, shift_joint(probe, 3, cur_tol + 1));
      // exactly on the tolerance opens it, still no results
      step = shift_joint(shift_joint(probe, 0, cur_tol), 9, -cur_tol);
      offer(CMD_COMMAND, step);
      offer(CMD_COMMAND, step);                      // unchanged command
      step = shift_joint(step, 5, cur_thr);
      offer(CMD_COMMAND, step);                      // move equal to threshold: held back
      step = shift_joint(step, 5, cur_thr + 1);
      offer(CMD_COMMAND, step);                      // just past threshold: forwarded
      for (int j = 0; j < ACTIVE_JOINTS; j++) step[j] = (j % 2) ? 16'h8000 : 16'h7fff;
      offer(CMD_COMMAND, step);                      // rails in the forwarded path
      offer(CMD_TICK, random_set());
      offer(CMD_UNUSED, random_set());

      // zero timeout: driver lost on the first tick, gate stays open across the loss
      settle();
      write_reg(CSR_TIMEOUT, 0);
      offer(CMD_TICK, random_set());
      offer(CMD_COMMAND, shift_joint(cmd_set, 1, 2000));   // offline, ignored
      offer(CMD_FEEDBACK, probe);
      offer(CMD_COMMAND, shift_joint(cmd_set, 2, -3000));  // back online, forwarded
      offer(CMD_TICK, random_set());

      // ---- phase with no idling, then a long receiver hold-off while ticks keep coming
      setup_phase(ALIGN_TOL_RESET, CHANGE_THR_RESET, 3);
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      send_random(50);
      hold_asked <= 1'b1;
      repeat (8) offer(CMD_TICK, random_set());
      send_random(45);

      // ---- sender mostly idle, widest tolerance, every change forwarded
      setup_phase(32767, 0, 1);
      send_idle_pct = 81;
      rsp_stall_pct <= 0;
      send_random(100);

      // ---- receiver mostly stalled, tightest tolerance, nothing short of a half-range swing moves
      setup_phase(0, 32767, int'(TICK_MAX));
      send_idle_pct = 0;
      rsp_stall_pct <= 81;
      send_random(50);
      settle();
      send_random(50);

      // ---- light idling on both sides, middling registers
      setup_phase(1000, 100, 8);
      send_idle_pct = 7;
      rsp_stall_pct <= 7;
      send_random(100);

      settle();
      $display("covered %0d request transactions: directed corners, then four idling phases",
               items_sent);
      $display("%0d result transactions matched, every register taken to both range ends",
               results_checked);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
